@@ src/salt_pkg.sv @@
// shared types, codes and helpers for the set-associative lru tracker
package salt_pkg;

    typedef enum logic [1:0] {
        KIND_LOAD   = 2'd0,
        KIND_STORE  = 2'd1,
        KIND_MODIFY = 2'd2,
        KIND_FETCH  = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        CFG_SET_INDEX_BITS    = 2'd0,
        CFG_WAYS_IN_USE       = 2'd1,
        CFG_BLOCK_OFFSET_BITS = 2'd2
    } t_cfg_index;

    localparam int MAX_OFFSET_BITS = 16;
    localparam int QUEUE_DEPTH     = 2;
    localparam int CFG_DATA_W      = 5;

    typedef struct packed {
        logic [3:0] set_index_bits;
        logic [2:0] ways_in_use;
        logic [4:0] block_offset_bits;
    } t_cfg;

    typedef struct packed {
        logic [1:0] hits_this_access;
        logic       missed;
        logic       evicted;
    } t_result_flags;

    function automatic logic [31:0] sat_add(input logic [31:0] v, input logic [1:0] inc);
        logic [32:0] sum;
        sum = {1'b0, v} + {31'd0, inc};
        return sum[32] ? 32'hFFFF_FFFF : sum[31:0];
    endfunction

endpackage

@@ src/salt_front.sv @@
// front end: takes requests, drops fetches, splits the address into set and tag
module salt_front
    import salt_pkg::*;
#(
    parameter int AW     = 32,
    parameter int SET_W  = 8,
    parameter int TAG_W  = 30,
    parameter int WCNT_W = 3,
    parameter int ITEM_W = 1 + WCNT_W + SET_W + TAG_W,
    parameter int MAX_WAYS = 4
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cfg              i_cfg,
    input  logic              i_accept,
    input  logic [1:0]        i_kind,
    input  logic [AW-1:0]     i_address,
    input  logic              i_q_full,
    output logic              o_ready,
    output logic              o_push,
    output logic [ITEM_W-1:0] o_item
);

    logic              r_v;
    logic [ITEM_W-1:0] r_item;
    logic [ITEM_W-1:0] n_item;
    logic              n_keep;

    always_comb begin
        int            s;
        int            b;
        int            wy;
        logic [AW-1:0] sh_b;
        logic [AW-1:0] sh_t;
        logic [SET_W-1:0] set_mask;
        logic [SET_W-1:0] set_idx;
        s  = int'(i_cfg.set_index_bits);
        b  = int'(i_cfg.block_offset_bits);
        wy = int'(i_cfg.ways_in_use);
        if (s < 1) s = 1;
        if (s > SET_W) s = SET_W;
        if (b < 1) b = 1;
        if (b > MAX_OFFSET_BITS) b = MAX_OFFSET_BITS;
        if (wy < 1) wy = 1;
        if (wy > MAX_WAYS) wy = MAX_WAYS;
        sh_b     = i_address >> b;
        sh_t     = i_address >> (s + b);
        set_mask = SET_W'((1 << s) - 1);
        set_idx  = sh_b[SET_W-1:0] & set_mask;
        n_item   = {(t_kind'(i_kind) == KIND_MODIFY), WCNT_W'(wy), set_idx, sh_t[TAG_W-1:0]};
        n_keep   = (t_kind'(i_kind) != KIND_FETCH);
    end

    assign o_push  = r_v && !i_q_full;
    assign o_ready = !r_v || !i_q_full;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (i_accept) begin
            r_v <= n_keep;
        end else if (o_push) begin
            r_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_item <= n_item;
        end
    end

endmodule

@@ src/salt_fifo.sv @@
// short queue between the front end and the lookup engine
module salt_fifo
    import salt_pkg::*;
#(
    parameter int W = 40
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_data,
    input  logic         i_pop,
    output logic [W-1:0] o_data,
    output logic         o_full,
    output logic         o_empty
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    logic [W-1:0]     r_data [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wp;
    logic [PTR_W-1:0] r_rp;
    logic [CNT_W-1:0] r_cnt;

    assign o_full  = (r_cnt == CNT_W'(QUEUE_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_data[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= (r_wp == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wp + PTR_W'(1);
            end
            if (i_pop) begin
                r_rp <= (r_rp == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rp + PTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + CNT_W'(1);
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_data[r_wp] <= i_data;
        end
    end

endmodule

@@ src/salt_back.sv @@
// lookup engine: valid-bit clearing after reset, set read, tag compare, lru victim scan, line write-back, totals
module salt_back
    import salt_pkg::*;
#(
    parameter int MAX_WAYS = 4,
    parameter int SET_W    = 8,
    parameter int TAG_W    = 30,
    parameter int WCNT_W   = 3,
    parameter int ITEM_W   = 1 + WCNT_W + SET_W + TAG_W
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_q_empty,
    input  logic [ITEM_W-1:0] i_q_item,
    output logic              o_pop,
    output logic              o_clearing,
    output logic              o_valid,
    output t_result_flags     o_flags,
    output logic [31:0]       o_total_hits,
    output logic [31:0]       o_total_misses,
    output logic [31:0]       o_total_evictions
);

    localparam int NUM_SETS = 1 << SET_W;
    localparam int WAY_W    = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;

    typedef enum logic [4:0] {
        ST_CLEAR = 5'b00001,
        ST_IDLE  = 5'b00010,
        ST_LOOK  = 5'b00100,
        ST_SCAN  = 5'b01000,
        ST_WRITE = 5'b10000
    } t_state;

    logic [MAX_WAYS-1:0]             mem_valid [NUM_SETS];
    logic [MAX_WAYS-1:0][TAG_W-1:0]  mem_tag   [NUM_SETS];
    logic [MAX_WAYS-1:0][31:0]       mem_stamp [NUM_SETS];

    t_state                          r_state;
    logic [SET_W-1:0]                r_clr_idx;
    logic                            r_mod;
    logic [WCNT_W-1:0]               r_ways;
    logic [SET_W-1:0]                r_set;
    logic [TAG_W-1:0]                r_tag;
    logic [MAX_WAYS-1:0]             r_rd_valid;
    logic [MAX_WAYS-1:0][TAG_W-1:0]  r_rd_tag;
    logic [MAX_WAYS-1:0][31:0]       r_rd_stamp;
    logic                            r_hit;
    logic                            r_evict;
    logic [WAY_W-1:0]                r_way;
    logic [WAY_W-1:0]                r_scan;
    logic [31:0]                     r_oldest;
    logic [31:0]                     r_use_clock;
    logic [31:0]                     r_hit_cnt;
    logic [31:0]                     r_miss_cnt;
    logic [31:0]                     r_evict_cnt;
    logic                            r_out_valid;
    t_result_flags                   r_flags;

    logic                            q_mod;
    logic [WCNT_W-1:0]               q_ways;
    logic [SET_W-1:0]                q_set;
    logic [TAG_W-1:0]                q_tag;

    logic [MAX_WAYS-1:0]             hit_vec;
    logic [MAX_WAYS-1:0]             free_vec;
    logic [WAY_W-1:0]                hit_idx;
    logic [WAY_W-1:0]                free_idx;
    logic [31:0]                     scan_stamp;
    logic [31:0]                     n_stamp;
    logic [1:0]                      n_hits;
    logic [MAX_WAYS-1:0]             wr_valid_row;
    logic [MAX_WAYS-1:0][TAG_W-1:0]  wr_tag_row;
    logic [MAX_WAYS-1:0][31:0]       wr_stamp_row;
    logic                            valid_we;
    logic                            line_we;
    logic [SET_W-1:0]                wr_addr;

    assign {q_mod, q_ways, q_set, q_tag} = i_q_item;

    assign o_pop      = (r_state == ST_IDLE) && !i_q_empty;
    assign o_clearing = (r_state == ST_CLEAR);
    assign o_valid    = r_out_valid;
    assign o_flags    = r_flags;
    assign o_total_hits      = r_hit_cnt;
    assign o_total_misses    = r_miss_cnt;
    assign o_total_evictions = r_evict_cnt;

    // lowest matching way wins, lowest free way is filled first
    always_comb begin
        hit_idx  = '0;
        free_idx = '0;
        for (int w = MAX_WAYS - 1; w >= 0; w--) begin
            hit_vec[w]  = (w < int'(r_ways)) && r_rd_valid[w] && (r_rd_tag[w] == r_tag);
            free_vec[w] = (w < int'(r_ways)) && !r_rd_valid[w];
            if (hit_vec[w]) hit_idx = WAY_W'(w);
            if (free_vec[w]) free_idx = WAY_W'(w);
        end
    end

    assign scan_stamp = r_rd_stamp[r_scan];

    // a modify makes a second lookup that always hits the line just placed
    assign n_stamp = r_use_clock + (r_mod ? 32'd2 : 32'd1);
    assign n_hits  = {1'b0, r_hit} + {1'b0, r_mod};

    always_comb begin
        wr_valid_row = r_rd_valid;
        wr_tag_row   = r_rd_tag;
        wr_stamp_row = r_rd_stamp;
        wr_valid_row[r_way] = 1'b1;
        wr_tag_row[r_way]   = r_tag;
        wr_stamp_row[r_way] = n_stamp;
        if (r_state == ST_CLEAR) begin
            wr_valid_row = '0;
        end
    end

    assign valid_we = (r_state == ST_CLEAR) || (r_state == ST_WRITE);
    assign line_we  = (r_state == ST_WRITE);
    assign wr_addr  = (r_state == ST_CLEAR) ? r_clr_idx : r_set;

    always_ff @(posedge i_clk) begin
        if (valid_we) begin
            mem_valid[wr_addr] <= wr_valid_row;
        end
        if (line_we) begin
            mem_tag[wr_addr]   <= wr_tag_row;
            mem_stamp[wr_addr] <= wr_stamp_row;
        end
        if (o_pop) begin
            r_rd_valid <= mem_valid[q_set];
            r_rd_tag   <= mem_tag[q_set];
            r_rd_stamp <= mem_stamp[q_set];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr_idx   <= '0;
            r_use_clock <= '0;
            r_hit_cnt   <= '0;
            r_miss_cnt  <= '0;
            r_evict_cnt <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= 1'b0;
            case (r_state)
                ST_CLEAR: begin
                    r_clr_idx <= r_clr_idx + SET_W'(1);
                    if (r_clr_idx == SET_W'(NUM_SETS - 1)) begin
                        r_state <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (!i_q_empty) begin
                        r_state <= ST_LOOK;
                    end
                end
                ST_LOOK: begin
                    if ((|hit_vec) || (|free_vec) || (r_ways == WCNT_W'(1))) begin
                        r_state <= ST_WRITE;
                    end else begin
                        r_state <= ST_SCAN;
                    end
                end
                ST_SCAN: begin
                    if (WCNT_W'(r_scan) == r_ways - WCNT_W'(1)) begin
                        r_state <= ST_WRITE;
                    end
                end
                ST_WRITE: begin
                    r_use_clock <= n_stamp;
                    r_hit_cnt   <= sat_add(r_hit_cnt, n_hits);
                    r_miss_cnt  <= sat_add(r_miss_cnt, {1'b0, !r_hit});
                    r_evict_cnt <= sat_add(r_evict_cnt, {1'b0, r_evict});
                    r_out_valid <= 1'b1;
                    r_state     <= ST_IDLE;
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    // request fields and per-way search registers carry no reset
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_mod  <= q_mod;
            r_ways <= q_ways;
            r_set  <= q_set;
            r_tag  <= q_tag;
        end
        if (r_state == ST_LOOK) begin
            r_hit    <= |hit_vec;
            r_evict  <= !(|hit_vec) && !(|free_vec);
            r_oldest <= r_rd_stamp[0];
            r_scan   <= WAY_W'(1);
            if (|hit_vec) begin
                r_way <= hit_idx;
            end else if (|free_vec) begin
                r_way <= free_idx;
            end else begin
                r_way <= '0;
            end
        end
        if (r_state == ST_SCAN) begin
            if (scan_stamp < r_oldest) begin
                r_oldest <= scan_stamp;
                r_way    <= r_scan;
            end
            r_scan <= r_scan + WAY_W'(1);
        end
        if (r_state == ST_WRITE) begin
            r_flags.hits_this_access <= n_hits;
            r_flags.missed           <= !r_hit;
            r_flags.evicted          <= r_evict;
        end
    end

endmodule

@@ src/set_assoc_cache_lru_tracker.sv @@
// top level: lru cache directory with config registers, front end, queue and lookup engine
//
// requests: drive i_kind and i_address with start high; a request is taken at a
// clock edge where start is high and busy is low. instruction fetches are taken
// and dropped, they change nothing and give no result.
// results: one per load, store or modify, shown on the o_ ports for one cycle with
// o_valid high; the receiver cannot hold them off. totals saturate at all ones.
// config: i_cfg_valid/o_cfg_ready write channel, index 0 set index bits,
// 1 ways in use, 2 block offset bits; o_cfg_ready is always high. write only
// while no request is in flight. stored lines survive a config change.
// path: after the accepting edge a request passes the front register, then the
// queue, set read, compare and write-back before o_valid rises, with a scan of
// the set for its oldest line before write-back when a full set must be searched.
// engine: a new request is popped only after the last one is written back, in the
// single-port set memory read-compare-write loop; a modify does both lookups in
// one pass. the two-entry queue lets the front keep taking requests while the
// engine works.
// reset: synchronous, active low. afterwards a clearing pass over all
// 2^floor(log2(MAX_SETS)) sets (256 by default) wipes the valid bits; busy stays high during it.
module set_assoc_cache_lru_tracker
    import salt_pkg::*;
#(
    parameter int MAX_SETS   = 256,
    parameter int MAX_WAYS   = 4,
    parameter int ADDR_WIDTH = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic [1:0]            i_kind,
    input  logic [31:0]           i_address,
    output logic                  o_valid,
    output logic [1:0]            o_hits_this_access,
    output logic                  o_missed,
    output logic                  o_evicted,
    output logic [31:0]           o_total_hits,
    output logic [31:0]           o_total_misses,
    output logic [31:0]           o_total_evictions,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [1:0]            i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int AW     = (ADDR_WIDTH < 32) ? ADDR_WIDTH : 32;
    localparam int SET_W  = $clog2(MAX_SETS + 1) - 1;
    localparam int TAG_W  = AW - 2;
    localparam int WCNT_W = $clog2(MAX_WAYS + 1);
    localparam int ITEM_W = 1 + WCNT_W + SET_W + TAG_W;

    t_cfg              r_cfg;
    t_result_flags     w_flags;
    logic              w_accept;
    logic              w_front_ready;
    logic              w_push;
    logic              w_pop;
    logic              w_q_full;
    logic              w_q_empty;
    logic              w_clearing;
    logic [ITEM_W-1:0] w_front_item;
    logic [ITEM_W-1:0] w_q_item;

    assign o_cfg_ready = 1'b1;
    assign busy        = w_clearing || !w_front_ready;
    assign w_accept    = start && !busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.set_index_bits    <= 4'd4;
            r_cfg.ways_in_use       <= 3'd1;
            r_cfg.block_offset_bits <= 5'd4;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_SET_INDEX_BITS:    r_cfg.set_index_bits    <= i_cfg_data[3:0];
                CFG_WAYS_IN_USE:       r_cfg.ways_in_use       <= i_cfg_data[2:0];
                CFG_BLOCK_OFFSET_BITS: r_cfg.block_offset_bits <= i_cfg_data[4:0];
                default: begin
                end
            endcase
        end
    end

    salt_front #(
        .AW       (AW),
        .SET_W    (SET_W),
        .TAG_W    (TAG_W),
        .WCNT_W   (WCNT_W),
        .ITEM_W   (ITEM_W),
        .MAX_WAYS (MAX_WAYS)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_accept  (w_accept),
        .i_kind    (i_kind),
        .i_address (i_address[AW-1:0]),
        .i_q_full  (w_q_full),
        .o_ready   (w_front_ready),
        .o_push    (w_push),
        .o_item    (w_front_item)
    );

    salt_fifo #(
        .W (ITEM_W)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_front_item),
        .i_pop   (w_pop),
        .o_data  (w_q_item),
        .o_full  (w_q_full),
        .o_empty (w_q_empty)
    );

    salt_back #(
        .MAX_WAYS (MAX_WAYS),
        .SET_W    (SET_W),
        .TAG_W    (TAG_W),
        .WCNT_W   (WCNT_W),
        .ITEM_W   (ITEM_W)
    ) u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_q_empty         (w_q_empty),
        .i_q_item          (w_q_item),
        .o_pop             (w_pop),
        .o_clearing        (w_clearing),
        .o_valid           (o_valid),
        .o_flags           (w_flags),
        .o_total_hits      (o_total_hits),
        .o_total_misses    (o_total_misses),
        .o_total_evictions (o_total_evictions)
    );

    assign o_hits_this_access = w_flags.hits_this_access;
    assign o_missed           = w_flags.missed;
    assign o_evicted          = w_flags.evicted;

    // no request is taken while the valid bits are being wiped
    a_clear_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_clearing |-> busy)
        else $error("request accepted during clearing pass");

    a_evict_miss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_evicted |-> o_missed)
        else $error("eviction reported without a miss");

    a_hit_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_missed |-> o_hits_this_access != 2'd0)
        else $error("access with no miss reports no hit");

    // each request passes the whole read-compare-write loop, so results never come in a row
    a_result_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("results in back-to-back cycles");

endmodule
